// File: hdl/xcsp_pkg.sv
// ----------------------------------------------------------------------------
// xcsp_pkg
// Shared types, codes and the hex digit decoder for the sentence parser.
// ----------------------------------------------------------------------------
`default_nettype none

package xcsp_pkg;

  localparam int IDENT_MAX   = 7;
  localparam int IDENT_W     = 8 * IDENT_MAX;
  localparam int VLEN_MAX    = 31;

  // configuration register indexes
  localparam logic [1:0] CFG_START_MARKER    = 2'd0;
  localparam logic [1:0] CFG_CHECKSUM_MARKER = 2'd1;
  localparam logic [1:0] CFG_FIELD_SEPARATOR = 2'd2;

  localparam logic [7:0] START_MARKER_RST    = 8'h24;
  localparam logic [7:0] CHECKSUM_MARKER_RST = 8'h2A;
  localparam logic [7:0] FIELD_SEPARATOR_RST = 8'h2C;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_BAD_HEX  = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_BAD_IDENT = 3'd3,
    ST_EMPTY_VALUE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_WAIT = 4'b0001,
    PH_BODY = 4'b0010,
    PH_CSHI = 4'b0100,
    PH_CSLO = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_t;

  typedef struct packed {
    status_t              frame_status;
    logic [IDENT_W-1:0]   ident_text;
    logic [2:0]           ident_length;
    logic [4:0]           value_length;
    logic [7:0]           computed_sum;
    logic [7:0]           received_sum;
  } result_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok     = 1'b1;
    h.nibble = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.nibble = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.nibble = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.nibble = 4'(b - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: hdl/xor_checked_sentence_parser_unit.sv
// ----------------------------------------------------------------------------
// xor_checked_sentence_parser_unit
// Frames marker-delimited sentences, checks the XOR checksum, reports status.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while in_ready is high and frames
// sentences: start marker, body, checksum marker, two hex digits. Every
// accepted byte updates the frame registers in the same cycle. When its last
// hex digit is accepted, a sentence's status is registered into the result
// register, or into the one skid register while the output stalls; so input
// bytes keep flowing while a result waits, and in_ready drops only when both
// hold a result. A body longer than BODY_CAPACITY-1 bytes is dropped without
// a result. The three marker bytes must be written through the cfg port
// only while idle, which the block does not enforce; cfg_ready is always high.
`default_nettype none

module xor_checked_sentence_parser_unit
  import xcsp_pkg::*;
#(
  parameter int BODY_CAPACITY = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [7:0]          in_rx_byte,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [2:0]          out_frame_status,
  output      logic [IDENT_W-1:0]  out_ident_text,
  output      logic [2:0]          out_ident_length,
  output      logic [4:0]          out_value_length,
  output      logic [7:0]          out_computed_sum,
  output      logic [7:0]          out_received_sum,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_wdata
);

  localparam int CNT_W = $clog2(BODY_CAPACITY);
  localparam int EW    = CNT_W + 5;

  logic [7:0] start_marker_r, checksum_marker_r, field_separator_r;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   body_count_r, body_count_nxt;
  logic [7:0]         running_xor_r, running_xor_nxt;
  logic [3:0]         high_nibble_r, high_nibble_nxt;
  logic               sep_seen_r, sep_seen_nxt;
  logic [CNT_W-1:0]   sep_index_r, sep_index_nxt;
  logic [IDENT_W-1:0] ident_r, ident_nxt;

  result_t out_r, skid_r, res;
  logic    out_valid_r, skid_valid_r;
  logic    accept, emit;

  logic [EW-1:0] cnt_ext, sep_ext, vlen_full;
  logic [2:0]    idlen;
  logic [4:0]    vlen;
  hex_t          hex;
  logic [7:0]    rsum;
  logic          ident_bad;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r    <= START_MARKER_RST;
      checksum_marker_r <= CHECKSUM_MARKER_RST;
      field_separator_r <= FIELD_SEPARATOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_MARKER:    start_marker_r    <= cfg_wdata;
        CFG_CHECKSUM_MARKER: checksum_marker_r <= cfg_wdata;
        CFG_FIELD_SEPARATOR: field_separator_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // lengths derived from the frame as it stands
  always_comb begin
    cnt_ext   = EW'(body_count_r);
    sep_ext   = EW'(sep_index_r);
    vlen_full = cnt_ext - sep_ext - EW'(1);
    vlen      = 5'd0;
    if (sep_seen_r) begin
      idlen = (sep_ext > EW'(IDENT_MAX)) ? 3'(IDENT_MAX) : sep_ext[2:0];
      vlen  = (vlen_full > EW'(VLEN_MAX)) ? 5'(VLEN_MAX) : vlen_full[4:0];
    end else begin
      idlen = (cnt_ext > EW'(IDENT_MAX)) ? 3'(IDENT_MAX) : cnt_ext[2:0];
    end
    ident_bad = !sep_seen_r || (sep_ext == '0) || (sep_ext > EW'(IDENT_MAX));
  end

  always_comb begin
    hex             = hex_decode(in_rx_byte);
    phase_nxt       = phase_r;
    body_count_nxt  = body_count_r;
    running_xor_nxt = running_xor_r;
    high_nibble_nxt = high_nibble_r;
    sep_seen_nxt    = sep_seen_r;
    sep_index_nxt   = sep_index_r;
    ident_nxt       = ident_r;
    emit            = 1'b0;
    rsum            = {high_nibble_r, 4'd0};
    res.frame_status = ST_ACCEPTED;

    if (accept) begin
      case (phase_r)
        PH_WAIT: begin
          if (in_rx_byte == start_marker_r) begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (in_rx_byte == checksum_marker_r) begin
            phase_nxt = PH_CSHI;
          end else if (in_rx_byte == start_marker_r) begin
            body_count_nxt  = '0;
            running_xor_nxt = '0;
            sep_seen_nxt    = 1'b0;
            sep_index_nxt   = '0;
            ident_nxt       = '0;
          end else if (cnt_ext < EW'(BODY_CAPACITY - 1)) begin
            running_xor_nxt = running_xor_r ^ in_rx_byte;
            if (!sep_seen_r) begin
              if (in_rx_byte == field_separator_r) begin
                sep_seen_nxt  = 1'b1;
                sep_index_nxt = body_count_r;
              end else begin
                for (int i = 0; i < IDENT_MAX; i++) begin
                  if (cnt_ext == EW'(i)) begin
                    ident_nxt[8*i +: 8] = in_rx_byte;
                  end
                end
              end
            end
            body_count_nxt = body_count_r + CNT_W'(1);
          end else begin
            // overflow: drop the frame quietly
            phase_nxt = PH_WAIT;
          end
        end
        PH_CSHI: begin
          if (hex.ok) begin
            high_nibble_nxt = hex.nibble;
            phase_nxt       = PH_CSLO;
          end else begin
            emit             = 1'b1;
            rsum             = 8'd0;
            res.frame_status = ST_BAD_HEX;
            phase_nxt        = PH_WAIT;
          end
        end
        PH_CSLO: begin
          emit      = 1'b1;
          phase_nxt = PH_WAIT;
          if (!hex.ok) begin
            res.frame_status = ST_BAD_HEX;
          end else begin
            rsum = {high_nibble_r, hex.nibble};
            if (rsum != running_xor_r) begin
              res.frame_status = ST_MISMATCH;
            end else if (ident_bad) begin
              res.frame_status = ST_BAD_IDENT;
            end else if (vlen_full == '0) begin
              res.frame_status = ST_EMPTY_VALUE;
            end else begin
              res.frame_status = ST_ACCEPTED;
            end
          end
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase

      // any return to waiting clears the frame
      if (phase_nxt == PH_WAIT) begin
        body_count_nxt  = '0;
        running_xor_nxt = '0;
        high_nibble_nxt = '0;
        sep_seen_nxt    = 1'b0;
        sep_index_nxt   = '0;
        ident_nxt       = '0;
      end
    end

    res.ident_text   = ident_r;
    res.ident_length = idlen;
    res.value_length = vlen;
    res.computed_sum = running_xor_r;
    res.received_sum = rsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_WAIT;
      body_count_r  <= '0;
      running_xor_r <= '0;
      high_nibble_r <= '0;
      sep_seen_r    <= 1'b0;
      sep_index_r   <= '0;
      ident_r       <= '0;
    end else begin
      phase_r       <= phase_nxt;
      body_count_r  <= body_count_nxt;
      running_xor_r <= running_xor_nxt;
      high_nibble_r <= high_nibble_nxt;
      sep_seen_r    <= sep_seen_nxt;
      sep_index_r   <= sep_index_nxt;
      ident_r       <= ident_nxt;
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= emit;
      end
    end else if (emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (emit) begin
        out_r <= res;
      end
    end else if (emit) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = out_r.frame_status;
  assign out_ident_text   = out_r.ident_text;
  assign out_ident_length = out_r.ident_length;
  assign out_value_length = out_r.value_length;
  assign out_computed_sum = out_r.computed_sum;
  assign out_received_sum = out_r.received_sum;

endmodule

`default_nettype wire

// File: hdl/xcsp_checker.sv
// ----------------------------------------------------------------------------
// xcsp_checker
// Port-level checks on the sentence parser's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module xcsp_checker
  import xcsp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [2:0]         out_frame_status,
  input wire logic [IDENT_W-1:0] out_ident_text,
  input wire logic [2:0]         out_ident_length,
  input wire logic [4:0]         out_value_length,
  input wire logic [7:0]         out_computed_sum,
  input wire logic [7:0]         out_received_sum
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_status)
      && $stable(out_ident_text) && $stable(out_received_sum))
    else $error("result changed while stalled");

  // accepted sentences carry a matching checksum
  a_ok_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_ACCEPTED |-> out_computed_sum == out_received_sum)
    else $error("accepted sentence with checksum mismatch");

  // a mismatch status really means the sums differ
  a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_MISMATCH |-> out_computed_sum != out_received_sum)
    else $error("mismatch status with equal sums");

  // accepted sentences have an identifier and value text
  a_ok_lengths: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_ACCEPTED
      |-> out_ident_length != 3'd0 && out_value_length != 5'd0)
    else $error("accepted sentence with empty identifier or value");

  // nothing pending straight after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind xor_checked_sentence_parser_unit xcsp_checker u_xcsp_checker (.*);

`default_nettype wire

// File: bench/tb_xor_checked_sentence_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_xor_checked_sentence_parser_unit
// Self-checking bench for the XOR checked sentence parser.
// ----------------------------------------------------------------------------
// Feeds byte streams through the valid/ready input, keeps its own parser model
// updated on every accepted byte and compares each status transaction on the
// output, field by field, with the oldest predicted one. Directed sentences
// cover every status, marker collisions and body overflow; random traffic
// mixes well-formed sentences with noise and broken frames under three
// idling profiles, and a long receiver hold-off fills the output buffering.
module tb_xor_checked_sentence_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import xcsp_pkg::*;

  localparam int BODY_CAP       = 32;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_HEX_HI, FLAW_HEX_LO} sentence_flaw_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_frame_status;
  logic [IDENT_W-1:0] out_ident_text;
  logic [2:0]         out_ident_length;
  logic [4:0]         out_value_length;
  logic [7:0]         out_computed_sum;
  logic [7:0]         out_received_sum;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 2'd0;
  logic [7:0]         cfg_wdata = 8'h00;

  xor_checked_sentence_parser_unit #(.BODY_CAPACITY(BODY_CAP)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_status(out_frame_status), .out_ident_text(out_ident_text),
    .out_ident_length(out_ident_length), .out_value_length(out_value_length),
    .out_computed_sum(out_computed_sum), .out_received_sum(out_received_sum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // parser model state
  logic [7:0]         mk_start = START_MARKER_RST;
  logic [7:0]         mk_sum   = CHECKSUM_MARKER_RST;
  logic [7:0]         mk_sep   = FIELD_SEPARATOR_RST;
  phase_t             parse_ph = PH_WAIT;
  int                 body_cnt = 0;
  logic [7:0]         sum_acc = 8'h00;
  logic [3:0]         hi_nib = 4'h0;
  bit                 sep_seen = 1'b0;
  int                 sep_pos = 0;
  logic [IDENT_W-1:0] ident_acc = '0;

  result_t sentence_reports_due[$];

  int  send_gap_pct = 13;
  int  recv_stall_pct = 51;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  mismatch_count = 0;
  int  bytes_sent = 0;
  int  quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, 4'(c[3:0] + 4'd9)};
    return 5'b0_0000;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  function automatic void clear_frame();
    body_cnt  = 0;
    sum_acc   = 8'h00;
    hi_nib    = 4'h0;
    sep_seen  = 1'b0;
    sep_pos   = 0;
    ident_acc = '0;
  endfunction

  function automatic void queue_report(input status_t st, input logic [7:0] rsum);
    result_t r;
    int vlen;
    r.frame_status = st;
    r.ident_text   = ident_acc;
    if (sep_seen) begin
      r.ident_length = 3'(sep_pos > IDENT_MAX ? IDENT_MAX : sep_pos);
      vlen = body_cnt - sep_pos - 1;
      r.value_length = 5'(vlen > VLEN_MAX ? VLEN_MAX : vlen);
    end else begin
      r.ident_length = 3'(body_cnt > IDENT_MAX ? IDENT_MAX : body_cnt);
      r.value_length = 5'd0;
    end
    r.computed_sum = sum_acc;
    r.received_sum = rsum;
    sentence_reports_due.push_back(r);
    clear_frame();
    parse_ph = PH_WAIT;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [4:0] hv;
    logic [7:0] rsum;
    status_t    st;
    hv = hex_value(b);
    case (parse_ph)
      PH_WAIT: begin
        if (b == mk_start) begin
          clear_frame();
          parse_ph = PH_BODY;
        end
      end
      PH_BODY: begin
        // checksum marker wins over start marker, start marker over separator
        if (b == mk_sum) begin
          parse_ph = PH_CSHI;
        end else if (b == mk_start) begin
          clear_frame();
        end else if (body_cnt < BODY_CAP - 1) begin
          sum_acc ^= b;
          if (!sep_seen) begin
            if (b == mk_sep) begin
              sep_seen = 1'b1;
              sep_pos  = body_cnt;
            end else if (body_cnt < IDENT_MAX) begin
              ident_acc[8*body_cnt +: 8] = b;
            end
          end
          body_cnt++;
        end else begin
          // overflow: frame dropped without a report
          clear_frame();
          parse_ph = PH_WAIT;
        end
      end
      PH_CSHI: begin
        if (!hv[4]) begin
          queue_report(ST_BAD_HEX, 8'h00);
        end else begin
          hi_nib   = hv[3:0];
          parse_ph = PH_CSLO;
        end
      end
      default: begin
        rsum = {hi_nib, 4'h0};
        if (!hv[4]) begin
          st = ST_BAD_HEX;
        end else begin
          rsum[3:0] = hv[3:0];
          if (rsum != sum_acc) st = ST_MISMATCH;
          else if (!sep_seen || sep_pos == 0 || sep_pos > IDENT_MAX) st = ST_BAD_IDENT;
          else if (body_cnt - sep_pos - 1 == 0) st = ST_EMPTY_VALUE;
          else st = ST_ACCEPTED;
        end
        queue_report(st, rsum);
      end
    endcase
  endfunction

  function automatic void note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) note_error($sformatf("%s: expected %0h, got %0h", what, want, got));
  endfunction

  // outputs and handshakes are sampled on the falling edge ahead of the accepting edge
  always @(negedge clk) begin : check_report
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sentence_reports_due.size() == 0) begin
        note_error("status transaction with no sentence pending");
      end else begin
        want = sentence_reports_due.pop_front();
        check_field("frame_status", 64'(want.frame_status), 64'(out_frame_status));
        check_field("ident_text",   64'(want.ident_text),   64'(out_ident_text));
        check_field("ident_length", 64'(want.ident_length), 64'(out_ident_length));
        check_field("value_length", 64'(want.value_length), 64'(out_value_length));
        check_field("computed_sum", 64'(want.computed_sum), 64'(out_computed_sum));
        check_field("received_sum", 64'(want.received_sum), 64'(out_received_sum));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_xor_checked_sentence_parser_unit: errors");
        $finish;
      end
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sentence_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      CFG_START_MARKER:    mk_start = val;
      CFG_CHECKSUM_MARKER: mk_sum   = val;
      CFG_FIELD_SEPARATOR: mk_sep   = val;
      default: ;
    endcase
  endtask

  task automatic set_markers(input logic [7:0] s, input logic [7:0] c, input logic [7:0] f);
    wait_quiet();
    write_reg(CFG_START_MARKER, s);
    write_reg(CFG_CHECKSUM_MARKER, c);
    write_reg(CFG_FIELD_SEPARATOR, f);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] body_byte(input bit ident_part);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == mk_start || b == mk_sum || (ident_part && b == mk_sep));
    return b;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    logic [4:0] hv;
    do begin
      b  = 8'($urandom_range(0, 255));
      hv = hex_value(b);
    end while (hv[4]);
    return b;
  endfunction

  // checksum marker and digits for the body sent so far
  task automatic send_trailer(input sentence_flaw_t flaw);
    logic [7:0] sent_sum;
    bit lower;
    sent_sum = sum_acc;
    if (flaw == FLAW_SUM) sent_sum ^= 8'($urandom_range(1, 255));
    lower = 1'($urandom_range(0, 1));
    send_byte(mk_sum);
    if (flaw == FLAW_HEX_HI) begin
      send_byte(non_hex());
    end else begin
      send_byte(hex_char(sent_sum[7:4], lower));
      send_byte(flaw == FLAW_HEX_LO ? non_hex() : hex_char(sent_sum[3:0], lower));
    end
  endtask

  task automatic send_sentence(input int ident_len, input bit with_sep, input int value_len,
                               input sentence_flaw_t flaw);
    send_byte(mk_start);
    repeat (ident_len) send_byte(body_byte(1'b1));
    if (with_sep) send_byte(mk_sep);
    repeat (value_len) send_byte(body_byte(1'b0));
    send_trailer(flaw);
  endtask

  task automatic pick_markers(output logic [7:0] s, output logic [7:0] c,
                              output logic [7:0] f);
    s = 8'($urandom_range(0, 255));
    do c = 8'($urandom_range(0, 255)); while (c == s);
    do f = 8'($urandom_range(0, 255)); while (f == s || f == c);
  endtask

  task automatic test_default_markers();
    send_byte(mk_start);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(mk_sep);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_trailer(FLAW_NONE);
    send_byte(mk_start);
    send_byte("G");
    send_byte(mk_sep);
    send_byte("1");
    send_trailer(FLAW_SUM);
    // empty body, bad first digit just below the digit range
    send_byte(mk_start);
    send_byte(mk_sum);
    send_byte(8'h2F);
    send_byte(mk_start);
    send_byte(mk_sum);
    send_byte("F");
    send_byte("g");
    send_byte(mk_start);
    send_byte("A");
    send_byte(mk_sep);
    send_byte("B");
    send_trailer(FLAW_HEX_LO);
    send_byte(mk_start);
    send_byte(mk_sep);
    send_byte("A");
    send_trailer(FLAW_NONE);
    send_byte(mk_start);
    send_byte("A");
    send_byte("B");
    send_trailer(FLAW_NONE);
    send_byte(mk_start);
    send_byte("A");
    send_byte(mk_sep);
    send_trailer(FLAW_NONE);
    send_sentence(8, 1'b1, 2, FLAW_NONE);
    // start marker inside the body resynchronises
    send_byte(mk_start);
    send_byte("A");
    send_byte(mk_start);
    send_byte("B");
    send_byte(mk_sep);
    send_byte("C");
    send_trailer(FLAW_NONE);
  endtask

  task automatic test_marker_collisions();
    // start and checksum markers equal: the same byte opens and closes
    set_markers(8'h00, 8'h00, 8'hFF);
    send_byte(mk_start);
    send_byte("A");
    send_byte(mk_sep);
    send_byte("B");
    send_trailer(FLAW_NONE);
    // separator equal to checksum marker: the body ends there
    set_markers(8'hFF, 8'h2C, 8'h2C);
    send_byte(mk_start);
    send_byte("A");
    send_trailer(FLAW_NONE);
    // separator equal to start marker: restarts instead
    wait_quiet();
    write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
    write_reg(CFG_START_MARKER, 8'hFF);
    write_reg(CFG_CHECKSUM_MARKER, 8'h00);
    write_reg(CFG_FIELD_SEPARATOR, 8'hFF);
    cfg_valid <= 1'b0;
    send_byte(mk_start);
    send_byte("A");
    send_byte(mk_sep);
    send_byte("B");
    send_trailer(FLAW_NONE);
  endtask

  task automatic test_body_overflow();
    logic [7:0] s, c, f;
    pick_markers(s, c, f);
    set_markers(s, c, f);
    send_sentence(3, 1'b1, BODY_CAP - 5, FLAW_NONE);
    send_byte(mk_start);
    repeat (BODY_CAP) send_byte(body_byte(1'b0));
    send_trailer(FLAW_NONE);
    send_sentence(2, 1'b1, 1, FLAW_NONE);
  endtask

  task automatic test_random_traffic(input int n_bytes, input int gap_pct, input int stall_pct);
    int first, kind, ident_len, room, value_len, r;
    bit with_sep;
    sentence_flaw_t flaw;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 68) begin
        r = $urandom_range(0, 9);
        ident_len = (r == 0) ? 0 : (r == 9) ? $urandom_range(8, 10) : $urandom_range(1, 7);
        with_sep  = ($urandom_range(0, 11) != 0);
        room      = BODY_CAP - 1 - ident_len - int'(with_sep);
        if (room == 0 || $urandom_range(0, 4) == 0) value_len = 0;
        else if ($urandom_range(0, 7) == 0) value_len = room;
        else value_len = $urandom_range(1, room < 12 ? room : 12);
        r = $urandom_range(0, 99);
        flaw = r < 60 ? FLAW_NONE : r < 75 ? FLAW_SUM : r < 88 ? FLAW_HEX_HI : FLAW_HEX_LO;
        send_sentence(ident_len, with_sep, value_len, flaw);
      end else if (kind < 82) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 94) begin
        // cut short, the next start marker resynchronises
        send_byte(mk_start);
        repeat ($urandom_range(0, 8)) send_byte(body_byte(1'b0));
      end else begin
        send_byte(mk_start);
        repeat ($urandom_range(BODY_CAP - 3, BODY_CAP + 1)) send_byte(body_byte(1'b0));
        send_trailer(FLAW_NONE);
      end
    end
  endtask

  task automatic test_output_backpressure();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    hold_request = 1'b1;
    @(posedge clk);
    repeat (10) send_sentence($urandom_range(1, 5), 1'b1, $urandom_range(1, 3), FLAW_NONE);
  endtask

  initial begin : run
    logic [7:0] s, c, f;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_markers();
    test_marker_collisions();
    test_body_overflow();
    set_markers(8'hFF, 8'h00, 8'h7F);
    test_random_traffic(330, 13, 51);
    pick_markers(s, c, f);
    set_markers(s, c, f);
    test_random_traffic(330, 51, 13);
    set_markers(START_MARKER_RST, CHECKSUM_MARKER_RST, FIELD_SEPARATOR_RST);
    test_random_traffic(340, 0, 0);
    test_output_backpressure();
    wait_quiet();
    if (mismatch_count == 0) begin
      $display("tb_xor_checked_sentence_parser_unit: clean");
    end else begin
      $display("tb_xor_checked_sentence_parser_unit: errors");
    end
    $finish;
  end

endmodule

// File: xor_checked_sentence_parser_unit.f
hdl/xcsp_pkg.sv
hdl/xor_checked_sentence_parser_unit.sv
hdl/xcsp_checker.sv
bench/tb_xor_checked_sentence_parser_unit.sv
